@@ hw/rtl/imh_pkg.sv @@
// Package: types and constants shared by the indexed min-heap modules.
`timescale 1ns / 1ps
package imh_pkg;
	localparam int Capacity = 1024;
	localparam int PosW = $clog2(Capacity);
	localparam int CntW = PosW + 1;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_PEEK   = 3'd1;
	localparam logic [2:0] OP_DELMIN = 3'd2;
	localparam logic [2:0] OP_DELH   = 3'd3;
	localparam logic [2:0] OP_MODH   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BADH  = 2'd3;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [9:0]        handle;
		logic signed [31:0] value;
	} imh_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] min_value;
		logic [9:0]         new_handle;
		logic [10:0]        occupancy;
	} imh_out_t;

	// One word of the position-indexed store: value and owning handle.
	typedef struct packed {
		logic signed [31:0] val;
		logic [PosW-1:0]    hnd;
	} imh_ent_t;
endpackage

@@ hw/rtl/indexed_min_heap.sv @@
// Top level of the indexed min-heap: sequencer, stores and result register.
`timescale 1ns / 1ps
// The block holds up to 1024 signed 32-bit values in a binary min-heap and
// gives each inserted value a handle, counting up from zero in insertion
// order; handles are never reused.
// Commands arrive on the input channel (valid/stall) as one beat carrying an
// opcode, a handle and a value. Every command yields exactly one result beat
// on the output channel with a status, the current minimum, the handle given
// by an insert and the occupancy.
// One command at a time is executed by a small sequencer around one shared
// signed comparator and the single read port of the entry memory. A peek, a
// full heap, an empty heap, an unknown opcode or an unissued handle goes
// straight to reading the minimum; a dead handle is rejected once its mapped
// position or its entry has been checked. Each sift-up level steps through
// S_UP_RD, S_UP_CMP and S_SWAP2, each sift-down level through S_DN_RD,
// S_DN_RD2, S_DN_SEL, S_DN_CMP and S_SWAP2. The input stall is high while a
// command runs and while the previous result has not been taken, so the next
// command is accepted at the earliest in the cycle after the result is taken.
// At reset the heap is empty and no handle has been issued; the memories are
// not cleared, since a handle is only trusted when it is below the next free
// handle and its mapped position holds it.
// While the receiver stalls, the result beat is held unchanged.
module indexed_min_heap
	import imh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  imh_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output imh_out_t out_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_HCHK1, S_HCHK2, S_RMLAST, S_RMLAST2, S_DN_RD, S_DN_RD2,
		S_DN_SEL, S_DN_CMP, S_UP_RD, S_UP_CMP, S_SWAP2, S_MIN_RD, S_MIN_WT, S_DONE
	} state_t;

	state_t state_q;
	imh_in_t cmd_q;
	logic [CntW-1:0] count_q, nexth_q;
	logic [PosW-1:0] p_q, c_q;
	logic [1:0] status_q;
	logic [9:0] newh_q;
	logic up_after_q;     // swap belongs to sift-up
	imh_ent_t cur_q, a_q;   // current element and the chosen child

	// Entry memory (value, handle) by position; the single read port is shared.
	logic            ent_we;
	logic [PosW-1:0] ent_wa, ent_ra;
	imh_ent_t        ent_wd, ent_rd;
	imh_ram #(.Width($bits(imh_ent_t)), .Depth(Capacity)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
		.raddr(ent_ra), .rdata(ent_rd)
	);

	// Handle to position map.
	logic            map_we;
	logic [PosW-1:0] map_wa, map_wd, map_ra, map_rd;
	imh_ram #(.Width(PosW), .Depth(Capacity)) u_map (
		.clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
		.raddr(map_ra), .rdata(map_rd)
	);

	// Shared signed comparator.
	logic signed [31:0] cmp_x, cmp_y;
	logic cmp_lt;
	assign cmp_lt = cmp_x < cmp_y;

	logic [CntW-1:0] lft_w, rgt_w;
	assign lft_w = {p_q, 1'b1};
	assign rgt_w = lft_w + 1'b1;
	logic lft_in, rgt_in;
	assign lft_in = ({1'b0, lft_w} < {1'b0, count_q});
	assign rgt_in = ({1'b0, rgt_w} < {1'b0, count_q});

	assign in_stall = (state_q != S_IDLE) || out_valid;

	always_comb begin
		ent_ra = p_q;
		map_ra = cmd_q.handle[PosW-1:0];
		cmp_x = a_q.val;
		cmp_y = cur_q.val;
		unique case (state_q)
			S_HCHK1:  ent_ra = map_rd;
			S_RMLAST: ent_ra = count_q[PosW-1:0] - 1'b1;
			S_DN_RD:  ent_ra = lft_w[PosW-1:0];
			S_DN_RD2: ent_ra = rgt_w[PosW-1:0];
			S_DN_SEL: begin
				// Right child against left child; a tie keeps the left one.
				cmp_x = ent_rd.val;
				cmp_y = a_q.val;
			end
			S_UP_RD:  ent_ra = (p_q - 1'b1) >> 1;
			S_UP_CMP: begin
				cmp_x = cur_q.val;
				cmp_y = ent_rd.val;
			end
			S_MIN_RD: ent_ra = '0;
			S_MIN_WT: ent_ra = '0;
			default:  ent_ra = p_q;
		endcase
	end

	// Write ports are registered requests issued by the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			count_q   <= '0;
			nexth_q   <= '0;
			ent_we    <= 1'b0;
			map_we    <= 1'b0;
		end else begin
			ent_we <= 1'b0;
			map_we <= 1'b0;
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						cmd_q    <= in_data;
						status_q <= ST_OK;
						newh_q   <= '0;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (cmd_q.opcode) inside
						OP_INSERT: begin
							if (count_q[PosW] || nexth_q[PosW]) begin
								status_q <= ST_FULL;
								state_q  <= S_MIN_RD;
							end else begin
								newh_q <= 10'(nexth_q);
								cur_q <= '{val: cmd_q.value, hnd: nexth_q[PosW-1:0]};
								p_q <= count_q[PosW-1:0];
								ent_we <= 1'b1; ent_wa <= count_q[PosW-1:0];
								ent_wd <= '{val: cmd_q.value, hnd: nexth_q[PosW-1:0]};
								map_we <= 1'b1; map_wa <= nexth_q[PosW-1:0];
								map_wd <= count_q[PosW-1:0];
								nexth_q <= nexth_q + 1'b1;
								count_q <= count_q + 1'b1;
								state_q <= S_UP_RD;
							end
						end
						OP_PEEK: begin
							if (count_q == '0) status_q <= ST_EMPTY;
							state_q <= S_MIN_RD;
						end
						OP_DELMIN: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_MIN_RD;
							end else begin
								p_q <= '0;
								state_q <= S_RMLAST;
							end
						end
						OP_DELH, OP_MODH: begin
							// A handle never issued is rejected at once.
							if ({1'b0, cmd_q.handle[PosW-1:0]} >= nexth_q) begin
								status_q <= ST_BADH;
								state_q  <= S_MIN_RD;
							end else begin
								state_q <= S_HCHK1;
							end
						end
						default: state_q <= S_MIN_RD;
					endcase
				end
				S_HCHK1: begin
					// The mapped position of a live handle lies inside the heap.
					p_q <= map_rd;
					if ({1'b0, map_rd} >= count_q) begin
						status_q <= ST_BADH;
						state_q  <= S_MIN_RD;
					end else begin
						state_q <= S_HCHK2;
					end
				end
				S_HCHK2: begin
					// A live handle is still held by its mapped position.
					if (ent_rd.hnd != cmd_q.handle[PosW-1:0]) begin
						status_q <= ST_BADH;
						state_q  <= S_MIN_RD;
					end else if (cmd_q.opcode == OP_MODH) begin
						cur_q <= '{val: cmd_q.value, hnd: cmd_q.handle[PosW-1:0]};
						ent_we <= 1'b1; ent_wa <= p_q;
						ent_wd <= '{val: cmd_q.value, hnd: cmd_q.handle[PosW-1:0]};
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_RMLAST;
					end
				end
				S_RMLAST: begin
					// Read of the last entry is in flight.
					state_q <= S_RMLAST2;
				end
				S_RMLAST2: begin
					count_q <= count_q - 1'b1;
					cur_q   <= ent_rd;
					if ({1'b0, p_q} == count_q - 1'b1) begin
						state_q <= S_MIN_RD;
					end else begin
						ent_we <= 1'b1; ent_wa <= p_q; ent_wd <= ent_rd;
						map_we <= 1'b1; map_wa <= ent_rd.hnd; map_wd <= p_q;
						state_q <= S_DN_RD;
					end
				end
				S_DN_RD: begin
					state_q <= lft_in ? S_DN_RD2 : S_UP_RD;
				end
				S_DN_RD2: begin
					a_q <= ent_rd;
					state_q <= S_DN_SEL;
				end
				S_DN_SEL: begin
					if (rgt_in && cmp_lt) begin
						a_q <= ent_rd;
						c_q <= rgt_w[PosW-1:0];
					end else begin
						c_q <= lft_w[PosW-1:0];
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (cmp_lt) begin
						up_after_q <= 1'b0;
						ent_we <= 1'b1; ent_wa <= p_q; ent_wd <= a_q;
						map_we <= 1'b1; map_wa <= a_q.hnd; map_wd <= p_q;
						state_q <= S_SWAP2;
					end else begin
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD: begin
					state_q <= (p_q == '0) ? S_MIN_RD : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_lt) begin
						c_q <= (p_q - 1'b1) >> 1;
						up_after_q <= 1'b1;
						ent_we <= 1'b1; ent_wa <= p_q; ent_wd <= ent_rd;
						map_we <= 1'b1; map_wa <= ent_rd.hnd; map_wd <= p_q;
						state_q <= S_SWAP2;
					end else begin
						state_q <= S_MIN_RD;
					end
				end
				S_SWAP2: begin
					ent_we <= 1'b1; ent_wa <= c_q; ent_wd <= cur_q;
					map_we <= 1'b1; map_wa <= cur_q.hnd; map_wd <= c_q;
					p_q <= c_q;
					state_q <= up_after_q ? S_UP_RD : S_DN_RD;
				end
				S_MIN_RD: state_q <= S_MIN_WT;
				S_MIN_WT: state_q <= S_DONE;
				S_DONE: begin
					out_data.status     <= status_q;
					out_data.min_value  <= (count_q == '0) ? '0 : ent_rd.val;
					out_data.new_handle <= newh_q;
					out_data.occupancy  <= 11'(count_q);
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_ready_only_idle;
		@(posedge clk) disable iff (!arst_n) !in_stall |-> state_q == S_IDLE;
	endproperty
	a_ready_only_idle: assert property (p_ready_only_idle) else $error("ready outside idle");

	property p_occ_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CntW'(Capacity);
	endproperty
	a_occ_bound: assert property (p_occ_bound) else $error("occupancy overflow");

	property p_count_le_handles;
		@(posedge clk) disable iff (!arst_n) count_q <= nexth_q;
	endproperty
	a_count_le_handles: assert property (p_count_le_handles) else $error("count above handles");
endmodule

@@ hw/rtl/imh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imh_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ tb/sv/tb_indexed_min_heap.sv @@
// Testbench for indexed_min_heap: random and directed commands against a heap predictor.
`timescale 1ns / 1ps
// Commands are queued by an initial block and sent by a clocked driver in
// bursts with random gaps. A clocked monitor takes result beats, with the
// receiver stalling on its own pattern, and compares each one with the
// oldest prediction. The predictor keeps its own copy of the heap, the
// position and handle maps and the live bits. It updates that copy when a
// command beat is accepted.
module tb_indexed_min_heap
	import imh_pkg::*;
();

	localparam int WatchLimit = 20000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	imh_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	imh_out_t out_data;

	indexed_min_heap DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Predictor state: a mirror of the block's heap.
	logic signed [31:0] pv_val [Capacity];
	int                 pv_hnd [Capacity];
	int                 hnd_pos [Capacity];
	bit                 hnd_live [Capacity];
	int                 pv_count;
	int                 next_hnd;

	imh_in_t  cmd_q [$];
	imh_out_t result_q [$];
	int       errors;
	bit       stim_done;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	function automatic void swap_entries(input int i, input int j);
		int                 hi;
		logic signed [31:0] v;
		hi = pv_hnd[i];
		hnd_pos[hi] = j;
		hnd_pos[pv_hnd[j]] = i;
		pv_hnd[i] = pv_hnd[j];
		pv_hnd[j] = hi;
		v = pv_val[i];
		pv_val[i] = pv_val[j];
		pv_val[j] = v;
	endfunction

	function automatic void sift_heap(input int start);
		int p;
		int b;
		int l;
		p = start;
		while (p < pv_count) begin
			b = p;
			l = 2 * p + 1;
			if (l < pv_count && pv_val[l] < pv_val[b]) b = l;
			if (l + 1 < pv_count && pv_val[l + 1] < pv_val[b]) b = l + 1;
			if (b == p) break;
			swap_entries(p, b);
			p = b;
		end
		while (p > 0 && p < pv_count) begin
			if (!(pv_val[p] < pv_val[(p - 1) / 2])) break;
			swap_entries(p, (p - 1) / 2);
			p = (p - 1) / 2;
		end
	endfunction

	function automatic void remove_entry(input int p);
		hnd_live[pv_hnd[p]] = 1'b0;
		if (p != pv_count - 1) swap_entries(p, pv_count - 1);
		pv_count--;
		if (p < pv_count) sift_heap(p);
	endfunction

	function automatic imh_out_t heap_apply(input imh_in_t c);
		imh_out_t r;
		int       p;
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_INSERT: begin
				if (pv_count >= Capacity || next_hnd >= Capacity) begin
					r.status = ST_FULL;
				end else begin
					p = pv_count;
					r.new_handle = next_hnd[9:0];
					pv_val[p] = c.value;
					pv_hnd[p] = next_hnd;
					hnd_pos[next_hnd] = p;
					hnd_live[next_hnd] = 1'b1;
					next_hnd++;
					pv_count++;
					sift_heap(p);
				end
			end
			OP_PEEK: if (pv_count == 0) r.status = ST_EMPTY;
			OP_DELMIN: begin
				if (pv_count == 0) r.status = ST_EMPTY;
				else remove_entry(0);
			end
			OP_DELH: begin
				if (!hnd_live[c.handle]) r.status = ST_BADH;
				else remove_entry(hnd_pos[c.handle]);
			end
			OP_MODH: begin
				if (!hnd_live[c.handle]) begin
					r.status = ST_BADH;
				end else begin
					p = hnd_pos[c.handle];
					pv_val[p] = c.value;
					sift_heap(p);
				end
			end
			default: ;
		endcase
		r.min_value = (pv_count > 0) ? pv_val[0] : 32'sd0;
		r.occupancy = pv_count[10:0];
		return r;
	endfunction

	// Stimulus builder: a shadow of which handles are live, so that most
	// delete and modify commands reach a real element.
	int sh_live [$];
	int sh_next;

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $signed(32'($urandom_range(0, 15)) - 32'd8);
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic push_cmd(input logic [2:0] op, input int h, input logic signed [31:0] v);
		imh_in_t c;
		int      k;
		c.opcode = op;
		c.handle = h[9:0];
		c.value = v;
		cmd_q.push_back(c);
		case (op)
			OP_INSERT: if (sh_next < Capacity) begin
				sh_live.push_back(sh_next);
				sh_next++;
			end
			OP_DELH: for (k = 0; k < sh_live.size(); k++)
				if (sh_live[k] == h) begin
					sh_live.delete(k);
					break;
				end
			default: ;
		endcase
	endtask

	// A delete-min takes an element whose handle the builder cannot tell,
	// so after one the shadow list is only a hint; a stale handle simply
	// yields an invalid-handle status, which is also wanted.
	function automatic int live_pick();
		if (sh_live.size() == 0) return $urandom_range(0, 1023);
		return sh_live[$urandom_range(0, sh_live.size() - 1)];
	endfunction

	initial begin
		int          i;
		int          n;
		int          op;
		logic [2:0]  junk;
		errors = 0;
		stim_done = 1'b0;
		sh_next = 0;
		pv_count = 0;
		next_hnd = 0;
		for (i = 0; i < Capacity; i++) hnd_live[i] = 1'b0;
		// Directed: empty peek and delete, bad handles, value extremes,
		// ties, modify up and down, deleting the last position, odd opcodes.
		push_cmd(OP_PEEK, 0, 0);
		push_cmd(OP_DELMIN, 0, 0);
		push_cmd(OP_DELH, 0, 0);
		push_cmd(OP_MODH, 1023, 5);
		push_cmd(OP_INSERT, 1023, 32'sh7fff_ffff);
		push_cmd(OP_INSERT, 0, 32'sh8000_0000);
		push_cmd(OP_INSERT, 0, 32'sd0);
		push_cmd(OP_INSERT, 0, 32'sd0);
		push_cmd(OP_INSERT, 0, -32'sd1);
		push_cmd(OP_PEEK, 0, 0);
		push_cmd(OP_MODH, 1, 32'sh7fff_ffff);
		push_cmd(OP_MODH, 0, 32'sh8000_0000);
		push_cmd(OP_DELH, 4, 0);
		push_cmd(OP_DELH, 4, 0);
		push_cmd(OP_DELH, 999, 0);
		push_cmd(OP_DELMIN, 0, 0);
		for (junk = 3'd5; junk != 3'd0; junk++) push_cmd(junk, $urandom_range(0, 1023), $urandom);
		push_cmd(OP_DELH, 2, 0);
		push_cmd(OP_DELMIN, 0, 0);
		push_cmd(OP_DELMIN, 0, 0);
		push_cmd(OP_DELMIN, 0, 0);
		// Random: phases that grow and shrink the heap, then a fill that
		// uses up the handle space and tests the full case.
		for (i = 0; i < 400; i++) begin
			n = (i / 200) % 2;
			op = $urandom_range(0, 99);
			if (op < (n ? 25 : 45)) push_cmd(OP_INSERT, $urandom_range(0, 1023), pick_value());
			else if (op < 52) push_cmd(OP_PEEK, $urandom_range(0, 1023), $urandom);
			else if (op < (n ? 72 : 62)) push_cmd(OP_DELMIN, $urandom_range(0, 1023), $urandom);
			else if (op < 80) push_cmd(OP_DELH, live_pick(), $urandom);
			else if (op < 95) push_cmd(OP_MODH, live_pick(), pick_value());
			else if (op < 98) push_cmd(OP_DELH, $urandom_range(0, 1023), $urandom);
			else push_cmd(3'($urandom_range(5, 7)), $urandom_range(0, 1023), $urandom);
		end
		while (sh_next < Capacity) push_cmd(OP_INSERT, $urandom_range(0, 1023), pick_value());
		for (i = 0; i < 300; i++) begin
			op = $urandom_range(0, 5);
			if (op < 2) push_cmd(OP_INSERT, 0, pick_value());
			else if (op < 4) push_cmd(OP_DELMIN, 0, 0);
			else if (op < 5) push_cmd(OP_MODH, live_pick(), pick_value());
			else push_cmd(OP_DELH, live_pick(), 0);
		end
		stim_done = 1'b1;
	end

	// Reset, then wait until every command is sent and answered.
	int idle_cycles;
	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && cmd_q.size() == 0 && !in_valid && result_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && result_q.size() == 0) $display("tb_indexed_min_heap OK");
		else $display("tb_indexed_min_heap NOT OK");
		$finish;
	end

	// Driver: bursts of beats separated by random gaps.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) result_q.push_back(heap_apply(in_data));
			if (in_valid && in_stall) begin
				// held beat stays as it is
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_q.size() > 0 && stim_done) begin
				in_valid <= 1'b1;
				in_data <= cmd_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: the receiver stalls in stretches of its own.
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		imh_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_phase <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report("unexpected beat", 64'(out_data), 64'd0);
				end else begin
					want = result_q.pop_front();
					if (out_data.status !== want.status)
						report("status", 64'(out_data.status), 64'(want.status));
					if (out_data.min_value !== want.min_value)
						report("min_value", 64'(out_data.min_value), 64'(want.min_value));
					if (out_data.new_handle !== want.new_handle)
						report("new_handle", 64'(out_data.new_handle),
							64'(want.new_handle));
					if (out_data.occupancy !== want.occupancy)
						report("occupancy", 64'(out_data.occupancy), 64'(want.occupancy));
				end
			end
			stall_phase <= (stall_phase + 1) % 512;
			if (stall_phase < 200) out_stall <= 1'b0;
			else if (stall_phase < 350) out_stall <= ($urandom_range(0, 3) == 0);
			else out_stall <= ($urandom_range(0, 9) < 7);
		end
	end

	// Watchdog: cycles without any accepted beat on either channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchLimit) begin
			$display("tb_indexed_min_heap NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end
endmodule

@@ filelist.f @@
hw/rtl/imh_pkg.sv
hw/rtl/imh_ram.sv
hw/rtl/indexed_min_heap.sv
tb/sv/tb_indexed_min_heap.sv
